// ----- hdl/hdg_pkg.sv -----
// Shared types, constants and the arctangent table for the compass heading pipeline.
package hdg_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TAB_LEN          = 24;

	localparam int MAG_W     = 16;
	localparam int FRAC_BITS = 8;
	localparam int VEC_W     = 27;
	localparam int ANG_FRAC  = 20;
	localparam int ANG_W     = 31;
	localparam int ZU_W      = 29;
	localparam int HDG_W     = 16;
	localparam int PROD_W    = ANG_FRAC + HDG_W;

	localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180) <<< ANG_FRAC;
	localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(360) <<< ANG_FRAC;
	localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (ANG_FRAC - 1);
	localparam logic [6:0] CENTI = 7'd100;
	localparam logic [HDG_W-1:0] FULL_TURN = 16'd36000;

	typedef logic signed [MAG_W-1:0] mag_t;
	typedef logic [HDG_W-1:0] heading_t;

	typedef struct packed {
		logic                    zero;
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
	} vec_t;

	// atan(2^-i) in units of 2^-20 degree
	function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] idx);
		logic signed [ANG_W-1:0] v;
		unique case (idx)
			5'd0:  v = 31'sd47185920;
			5'd1:  v = 31'sd27855475;
			5'd2:  v = 31'sd14718068;
			5'd3:  v = 31'sd7471121;
			5'd4:  v = 31'sd3750058;
			5'd5:  v = 31'sd1876857;
			5'd6:  v = 31'sd938658;
			5'd7:  v = 31'sd469357;
			5'd8:  v = 31'sd234682;
			5'd9:  v = 31'sd117342;
			5'd10: v = 31'sd58671;
			5'd11: v = 31'sd29335;
			5'd12: v = 31'sd14668;
			5'd13: v = 31'sd7334;
			5'd14: v = 31'sd3667;
			5'd15: v = 31'sd1833;
			5'd16: v = 31'sd917;
			5'd17: v = 31'sd458;
			5'd18: v = 31'sd229;
			5'd19: v = 31'sd115;
			5'd20: v = 31'sd57;
			5'd21: v = 31'sd29;
			5'd22: v = 31'sd14;
			5'd23: v = 31'sd7;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- hdl/compass_heading_from_magnetometer_top.sv -----
// Compass heading from a magnetometer X/Y pair.
//
// Input stream: s_axis carries one reading pair per transfer, X in the low half
// of tdata and Y in the high half, both signed raw counts.
// Output stream: m_axis carries one heading per input, in hundredths of a
// degree, 0 to 35999, with 0 along +X and angles growing toward +Y.
// The core is one input register, CORDIC_STEPS vectoring stages and three
// output stages (wrap, scale by 100, round). One pair is taken every cycle
// while the receiver keeps up. Every stage holds its own valid bit and takes a
// new item whenever it is empty or its successor is advancing, so bubbles
// close up while the receiver stalls and the input keeps filling empty stages
// until the pipeline is full. Reset clears all valid bits at once; no item is
// in flight afterward and the block is ready in the first cycle. A zero pair
// gives heading 0.
module compass_heading_from_magnetometer_top #(
	parameter int CORDIC_STEPS = hdg_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] mag_x, [31:16] mag_y
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [15:0] heading_centideg
);
	import hdg_pkg::*;

	logic lnk_valid [CORDIC_STEPS+1];
	logic lnk_ready [CORDIC_STEPS+1];
	vec_t lnk_data  [CORDIC_STEPS+1];
	mag_t mag_x;
	mag_t mag_y;

	assign mag_x = s_axis_tdata[MAG_W-1:0];
	assign mag_y = s_axis_tdata[2*MAG_W-1:MAG_W];

	hdg_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.mag_x     (mag_x),
		.mag_y     (mag_y),
		.out_valid (lnk_valid[0]),
		.out_ready (lnk_ready[0]),
		.out_data  (lnk_data[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		hdg_cordic_stage #(
			.STEP (i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (lnk_valid[i]),
			.in_ready  (lnk_ready[i]),
			.in_data   (lnk_data[i]),
			.out_valid (lnk_valid[i+1]),
			.out_ready (lnk_ready[i+1]),
			.out_data  (lnk_data[i+1])
		);
	end

	hdg_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lnk_valid[CORDIC_STEPS]),
		.in_ready  (lnk_ready[CORDIC_STEPS]),
		.in_data   (lnk_data[CORDIC_STEPS]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.heading   (m_axis_tdata)
	);

endmodule

// ----- hdl/hdg_pre.sv -----
// Input stage: scale the reading pair and fold the left half-plane onto the right.
module hdg_pre (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hdg_pkg::mag_t mag_x,
	input  hdg_pkg::mag_t mag_y,
	output logic          out_valid,
	input  logic          out_ready,
	output hdg_pkg::vec_t out_data
);
	import hdg_pkg::*;

	logic                    valid_s1;
	vec_t                    data_s1;
	vec_t                    nxt;
	logic signed [VEC_W-1:0] xs;
	logic signed [VEC_W-1:0] ys;

	assign in_ready = !valid_s1 || out_ready;

	assign xs = {{(VEC_W-MAG_W-FRAC_BITS){mag_x[MAG_W-1]}}, mag_x, {FRAC_BITS{1'b0}}};
	assign ys = {{(VEC_W-MAG_W-FRAC_BITS){mag_y[MAG_W-1]}}, mag_y, {FRAC_BITS{1'b0}}};

	always_comb begin
		nxt.zero = (mag_x == '0) && (mag_y == '0);
		if (xs < 0) begin
			nxt.x = -xs;
			nxt.y = -ys;
			nxt.z = DEG180;
		end else begin
			nxt.x = xs;
			nxt.y = ys;
			nxt.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ----- hdl/hdg_cordic_stage.sv -----
// One CORDIC vectoring iteration with its own pipeline register.
module hdg_cordic_stage #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hdg_pkg::vec_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output hdg_pkg::vec_t out_data
);
	import hdg_pkg::*;

	localparam logic signed [ANG_W-1:0] ATAN_STEP = atan_tab(5'(STEP));

	logic                    valid_s1;
	vec_t                    data_s1;
	vec_t                    nxt;
	logic signed [VEC_W-1:0] x_in;
	logic signed [VEC_W-1:0] y_in;
	logic signed [VEC_W-1:0] x_sh;
	logic signed [VEC_W-1:0] y_sh;

	assign in_ready = !valid_s1 || out_ready;

	assign x_in = in_data.x;
	assign y_in = in_data.y;
	assign x_sh = x_in >>> STEP;
	assign y_sh = y_in >>> STEP;

	// rotate toward the x axis, steering by the sign of y
	always_comb begin
		nxt.zero = in_data.zero;
		if (y_in >= 0) begin
			nxt.x = x_in + y_sh;
			nxt.y = y_in - x_sh;
			nxt.z = in_data.z + ATAN_STEP;
		end else begin
			nxt.x = x_in - y_sh;
			nxt.y = y_in + x_sh;
			nxt.z = in_data.z - ATAN_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ----- hdl/hdg_post.sv -----
// Output stages: wrap the angle into one turn, scale to centidegrees and round.
module hdg_post (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hdg_pkg::vec_t     in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output hdg_pkg::heading_t heading
);
	import hdg_pkg::*;

	logic                    valid_s1;
	logic                    valid_s2;
	logic                    valid_s3;
	logic                    rdy_s1;
	logic                    rdy_s2;
	logic                    rdy_s3;
	logic                    zero_s1;
	logic                    zero_s2;
	logic [ZU_W-1:0]         ang_s1;
	logic [PROD_W-1:0]       prod_s2;
	heading_t                hdg_s3;
	logic signed [ANG_W-1:0] z_wrap;
	logic [PROD_W-1:0]       rnd;
	heading_t                cent;

	assign rdy_s3   = !valid_s3 || out_ready;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign z_wrap = (in_data.z < 0) ? in_data.z + DEG360 : in_data.z;
	assign rnd    = prod_s2 + HALF_LSB;
	assign cent   = rnd[ANG_FRAC +: HDG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			ang_s1  <= z_wrap[ZU_W-1:0];
			zero_s1 <= in_data.zero;
		end
		if (rdy_s2 && valid_s1) begin
			prod_s2 <= PROD_W'(ang_s1) * PROD_W'(CENTI);
			zero_s2 <= zero_s1;
		end
		if (rdy_s3 && valid_s2) begin
			// a full turn after rounding folds back to zero
			if (zero_s2) begin
				hdg_s3 <= '0;
			end else if (cent >= FULL_TURN) begin
				hdg_s3 <= cent - FULL_TURN;
			end else begin
				hdg_s3 <= cent;
			end
		end
	end

	assign out_valid = valid_s3;
	assign heading   = hdg_s3;

endmodule

// ----- hdl/hdg_chk.sv -----
// Port-level checks for the compass heading block, bound to the top level.
module hdg_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);
	import hdg_pkg::*;

	// nothing is offered in the cycle after reset is seen
	a_idle_in_reset: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("output valid during reset");

	// an advancing output frees every stage, so the input must be open
	a_ready_flow: assert property (@(posedge clk) m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output advances");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata < FULL_TURN))
		else $error("heading out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output transfer changed");

endmodule

bind compass_heading_from_magnetometer_top hdg_chk u_hdg_chk (.*);
